@@ src/hsbrgb_pkg.sv @@
// hsbrgb_pkg: shared widths, sector codes and stage payload types
// for the hue/saturation/brightness to 5-bit rgb pipeline; no dependencies
`timescale 1ns / 1ps

package hsbrgb_pkg;

  localparam int CH_W      = 8;
  localparam int OUT_W     = 5;
  localparam int SECT_W    = 3;
  localparam int PROD_W    = 2 * CH_W;
  localparam int CHAN_SHIFT = CH_W - OUT_W;

  localparam logic [SECT_W-1:0] SECT_RED_RISE_G  = 3'd0;
  localparam logic [SECT_W-1:0] SECT_GREEN_FALL_R = 3'd1;
  localparam logic [SECT_W-1:0] SECT_GREEN_RISE_B = 3'd2;
  localparam logic [SECT_W-1:0] SECT_BLUE_FALL_G = 3'd3;
  localparam logic [SECT_W-1:0] SECT_BLUE_RISE_R = 3'd4;
  localparam logic [SECT_W-1:0] SECT_RED_FALL_B  = 3'd5;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [OUT_W-1:0]  chan5_t;
  typedef logic [SECT_W-1:0] sect_code_t;

  // after hue split
  typedef struct packed {
    logic       grey;
    sect_code_t sector;
    chan_t      off;
    chan_t      sat;
    chan_t      value;
  } sect_t;

  // after weight products: k terms of v*(255-k)>>8
  typedef struct packed {
    logic       grey;
    sect_code_t sector;
    chan_t      kp;
    chan_t      kq;
    chan_t      kt;
    chan_t      value;
  } weight_t;

  // after level products
  typedef struct packed {
    logic       grey;
    sect_code_t sector;
    chan_t      p;
    chan_t      q;
    chan_t      t;
    chan_t      value;
  } level_t;

endpackage

@@ src/hsbrgb_sector_stage.sv @@
// hsbrgb_sector_stage: first pipeline stage, splits hue*6 into sector and offset
// depends on hsbrgb_pkg
`timescale 1ns / 1ps

module hsbrgb_sector_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  output logic              ready_o,
  input  hsbrgb_pkg::chan_t hue_i,
  input  hsbrgb_pkg::chan_t sat_i,
  input  hsbrgb_pkg::chan_t value_i,
  output logic              valid_o,
  input  logic              ready_i,
  output hsbrgb_pkg::sect_t data_o
);

  logic                  valid_r;
  logic                  valid_nxt;
  hsbrgb_pkg::sect_t     data_r;
  hsbrgb_pkg::sect_t     data_nxt;
  logic [hsbrgb_pkg::CH_W+2:0] scaled;

  // hue*6 as (hue<<2) + (hue<<1)
  assign scaled = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};

  always_comb begin
    data_nxt.grey   = (sat_i == '0);
    data_nxt.sector = scaled[hsbrgb_pkg::CH_W +: hsbrgb_pkg::SECT_W];
    data_nxt.off    = scaled[hsbrgb_pkg::CH_W-1:0];
    data_nxt.sat    = sat_i;
    data_nxt.value  = value_i;
  end

  assign ready_o   = !valid_r || ready_i;
  assign valid_nxt = ready_o ? valid_i : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

@@ src/hsbrgb_weight_stage.sv @@
// hsbrgb_weight_stage: second stage, saturation times offset products
// depends on hsbrgb_pkg
`timescale 1ns / 1ps

module hsbrgb_weight_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  output logic                ready_o,
  input  hsbrgb_pkg::sect_t   data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hsbrgb_pkg::weight_t data_o
);

  logic                              valid_r;
  logic                              valid_nxt;
  hsbrgb_pkg::weight_t               data_r;
  hsbrgb_pkg::weight_t               data_nxt;
  logic [hsbrgb_pkg::PROD_W-1:0]     prod_q;
  logic [hsbrgb_pkg::PROD_W-1:0]     prod_t;

  assign prod_q = data_i.sat * data_i.off;
  // 255 - off as the 8-bit inverse, kept at 8 bits before the multiply
  assign prod_t = data_i.sat * hsbrgb_pkg::chan_t'(~data_i.off);

  always_comb begin
    data_nxt.grey   = data_i.grey;
    data_nxt.sector = data_i.sector;
    data_nxt.kp     = data_i.sat;
    data_nxt.kq     = prod_q[hsbrgb_pkg::PROD_W-1:hsbrgb_pkg::CH_W];
    data_nxt.kt     = prod_t[hsbrgb_pkg::PROD_W-1:hsbrgb_pkg::CH_W];
    data_nxt.value  = data_i.value;
  end

  assign ready_o   = !valid_r || ready_i;
  assign valid_nxt = ready_o ? valid_i : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

@@ src/hsbrgb_level_stage.sv @@
// hsbrgb_level_stage: third stage, brightness times (255 - k) for p, q and t
// depends on hsbrgb_pkg
`timescale 1ns / 1ps

module hsbrgb_level_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  output logic                ready_o,
  input  hsbrgb_pkg::weight_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hsbrgb_pkg::level_t  data_o
);

  logic                          valid_r;
  logic                          valid_nxt;
  hsbrgb_pkg::level_t            data_r;
  hsbrgb_pkg::level_t            data_nxt;
  logic [hsbrgb_pkg::PROD_W-1:0] prod_p;
  logic [hsbrgb_pkg::PROD_W-1:0] prod_q;
  logic [hsbrgb_pkg::PROD_W-1:0] prod_t;

  // 255 - k is the bitwise inverse of an 8-bit k
  assign prod_p = data_i.value * hsbrgb_pkg::chan_t'(~data_i.kp);
  assign prod_q = data_i.value * hsbrgb_pkg::chan_t'(~data_i.kq);
  assign prod_t = data_i.value * hsbrgb_pkg::chan_t'(~data_i.kt);

  always_comb begin
    data_nxt.grey   = data_i.grey;
    data_nxt.sector = data_i.sector;
    data_nxt.p      = prod_p[hsbrgb_pkg::PROD_W-1:hsbrgb_pkg::CH_W];
    data_nxt.q      = prod_q[hsbrgb_pkg::PROD_W-1:hsbrgb_pkg::CH_W];
    data_nxt.t      = prod_t[hsbrgb_pkg::PROD_W-1:hsbrgb_pkg::CH_W];
    data_nxt.value  = data_i.value;
  end

  assign ready_o   = !valid_r || ready_i;
  assign valid_nxt = ready_o ? valid_i : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

@@ src/hsbrgb_mux_stage.sv @@
// hsbrgb_mux_stage: last stage, places levels on channels by sector and
// truncates to 5 bits into the output register; depends on hsbrgb_pkg
`timescale 1ns / 1ps

module hsbrgb_mux_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  output logic               ready_o,
  input  hsbrgb_pkg::level_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output hsbrgb_pkg::chan5_t red_o,
  output hsbrgb_pkg::chan5_t green_o,
  output hsbrgb_pkg::chan5_t blue_o
);

  logic               valid_r;
  logic               valid_nxt;
  hsbrgb_pkg::chan_t  red8;
  hsbrgb_pkg::chan_t  green8;
  hsbrgb_pkg::chan_t  blue8;
  hsbrgb_pkg::chan5_t red_r;
  hsbrgb_pkg::chan5_t green_r;
  hsbrgb_pkg::chan5_t blue_r;

  always_comb begin
    if (data_i.grey) begin
      red8   = data_i.value;
      green8 = data_i.value;
      blue8  = data_i.value;
    end else begin
      unique case (data_i.sector)
        hsbrgb_pkg::SECT_RED_RISE_G: begin
          red8 = data_i.value; green8 = data_i.t; blue8 = data_i.p;
        end
        hsbrgb_pkg::SECT_GREEN_FALL_R: begin
          red8 = data_i.q; green8 = data_i.value; blue8 = data_i.p;
        end
        hsbrgb_pkg::SECT_GREEN_RISE_B: begin
          red8 = data_i.p; green8 = data_i.value; blue8 = data_i.t;
        end
        hsbrgb_pkg::SECT_BLUE_FALL_G: begin
          red8 = data_i.p; green8 = data_i.q; blue8 = data_i.value;
        end
        hsbrgb_pkg::SECT_BLUE_RISE_R: begin
          red8 = data_i.t; green8 = data_i.p; blue8 = data_i.value;
        end
        default: begin
          red8 = data_i.value; green8 = data_i.p; blue8 = data_i.q;
        end
      endcase
    end
  end

  assign ready_o   = !valid_r || ready_i;
  assign valid_nxt = ready_o ? valid_i : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      red_r   <= red8[hsbrgb_pkg::CH_W-1:hsbrgb_pkg::CHAN_SHIFT];
      green_r <= green8[hsbrgb_pkg::CH_W-1:hsbrgb_pkg::CHAN_SHIFT];
      blue_r  <= blue8[hsbrgb_pkg::CH_W-1:hsbrgb_pkg::CHAN_SHIFT];
    end
  end

  assign valid_o = valid_r;
  assign red_o   = red_r;
  assign green_o = green_r;
  assign blue_o  = blue_r;

endmodule

@@ src/hsb_to_rgb555_converter_top.sv @@
// hsb_to_rgb555_converter_top: four-stage colour conversion pipeline
// depends on hsbrgb_pkg and the hsbrgb_*_stage modules
`timescale 1ns / 1ps

// usage
// - input channel: in_valid/in_ready carry one transaction of 8-bit hue,
//   saturation and brightness (in_hue_in, in_sat_in, in_value_in)
// - result channel: out_valid/out_ready carry one transaction of 5-bit red,
//   green and blue (out_red_out, out_green_out, out_blue_out)
// - every input transaction gives exactly one result transaction, in order
// - pipeline: four register stages (sector split, saturation products,
//   brightness products, channel select), passed in order up to out_valid
// - throughput: one transaction per cycle while out_ready is high; each stage
//   holds one item and its own valid bit, so a new item enters while earlier
//   ones are still in flight
// - the deepest logic between registers is one 8x8 multiplier per level,
//   which sets the clock period
// - stall: when out_ready is low, the output register holds its result and the
//   hold propagates back only into stages that are full; bubbles collapse, so
//   in_ready drops only when all four stages hold an item
// - reset: synchronous, active low rst_n clears every valid bit; payload
//   registers are left as they are, nothing is emitted until new input arrives
// - no configuration, no state kept between transactions

module hsb_to_rgb555_converter_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_hue_in,
  input  logic [7:0]            in_sat_in,
  input  logic [7:0]            in_value_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [4:0]            out_red_out,
  output logic [4:0]            out_green_out,
  output logic [4:0]            out_blue_out
);

  // stage-to-stage links
  logic                sect_valid;
  logic                sect_ready;
  hsbrgb_pkg::sect_t   sect_data;
  logic                wgt_valid;
  logic                wgt_ready;
  hsbrgb_pkg::weight_t wgt_data;
  logic                lvl_valid;
  logic                lvl_ready;
  hsbrgb_pkg::level_t  lvl_data;

  // hue*6 split into sector and offset, grey flag
  hsbrgb_sector_stage u_sector (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .hue_i   (in_hue_in),
    .sat_i   (in_sat_in),
    .value_i (in_value_in),
    .valid_o (sect_valid),
    .ready_i (sect_ready),
    .data_o  (sect_data)
  );

  // s*off and s*(255-off), top byte kept
  hsbrgb_weight_stage u_weight (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (sect_valid),
    .ready_o (sect_ready),
    .data_i  (sect_data),
    .valid_o (wgt_valid),
    .ready_i (wgt_ready),
    .data_o  (wgt_data)
  );

  // p, q and t levels
  hsbrgb_level_stage u_level (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (wgt_valid),
    .ready_o (wgt_ready),
    .data_i  (wgt_data),
    .valid_o (lvl_valid),
    .ready_i (lvl_ready),
    .data_o  (lvl_data)
  );

  // channel select and output register
  hsbrgb_mux_stage u_mux (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (lvl_valid),
    .ready_o (lvl_ready),
    .data_i  (lvl_data),
    .valid_o (out_valid),
    .ready_i (out_ready),
    .red_o   (out_red_out),
    .green_o (out_green_out),
    .blue_o  (out_blue_out)
  );

`ifndef SYNTH
  // in_ready only drops when every stage is full and the output is stalled
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (sect_valid && wgt_valid && lvl_valid && out_valid && !out_ready))
    else $error("input stalled while pipeline has a free stage");

  // sector from hue*6 never exceeds five
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    sect_valid |-> (sect_data.sector <= hsbrgb_pkg::SECT_RED_FALL_B))
    else $error("sector out of range");

  // with out_ready held high, an accepted transaction raises out_valid at the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready
      |=> out_valid)
    else $error("result missing after four cycles");

  // a grey item gives three equal channels
  a_grey_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (lvl_valid && lvl_ready && lvl_data.grey) |=>
      (out_red_out == out_green_out && out_green_out == out_blue_out))
    else $error("grey transaction gave unequal channels");
`endif

endmodule

@@ verif/hsb_to_rgb555_converter_top_tb.sv @@
// hsb_to_rgb555_converter_top_tb: self-checking bench for the hsb to 5-bit rgb
// pipeline; predicts every colour and compares it field by field in order
// depends on hsbrgb_pkg and hsb_to_rgb555_converter_top
`timescale 1ns / 1ps

module hsb_to_rgb555_converter_top_tb;

  // one colour as the block returns it
  typedef struct packed {
    hsbrgb_pkg::chan5_t red;
    hsbrgb_pkg::chan5_t green;
    hsbrgb_pkg::chan5_t blue;
  } rgb555_t;

  // one pixel waiting to be offered; drain_first makes the sender wait until
  // every outstanding colour has come back before offering it
  typedef struct {
    hsbrgb_pkg::chan_t hue;
    hsbrgb_pkg::chan_t sat;
    hsbrgb_pkg::chan_t val;
    bit                drain_first;
  } hsb_px_t;

  localparam int RANDOM_PIXELS = 850;
  localparam int QUIET_LIMIT   = 1000;  // cycles with no transaction on either side
  localparam int TAIL_CYCLES   = 12;    // pipeline is four deep, allow a little over
  localparam int LONG_HOLD     = 60;    // receiver hold-off, well beyond pipeline depth
  localparam int HOLD_AT       = 250;   // colour count that triggers the hold-off
  localparam int CALM_LO       = 400;   // transaction counts with no idling on either side
  localparam int CALM_HI       = 560;

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  hsbrgb_pkg::chan_t  in_hue_in     = '0;
  hsbrgb_pkg::chan_t  in_sat_in     = '0;
  hsbrgb_pkg::chan_t  in_value_in   = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  hsbrgb_pkg::chan5_t out_red_out;
  hsbrgb_pkg::chan5_t out_green_out;
  hsbrgb_pkg::chan5_t out_blue_out;

  hsb_px_t pending_px[$];   // pixels not yet offered
  rgb555_t colour_due[$];   // predicted colours, oldest first

  int px_sent     = 0;
  int colour_seen = 0;
  int err_count   = 0;
  int hold_left   = 0;
  int quiet_cycles = 0;

  hsb_to_rgb555_converter_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_hue_in    (in_hue_in),
    .in_sat_in    (in_sat_in),
    .in_value_in  (in_value_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // brightness scaled down by (255 - k)/256, truncated
  function automatic hsbrgb_pkg::chan_t scale_level(hsbrgb_pkg::chan_t v,
                                                    hsbrgb_pkg::chan_t k);
    logic [hsbrgb_pkg::PROD_W-1:0] prod;
    prod = v * (8'd255 - k);
    return prod[hsbrgb_pkg::PROD_W-1:hsbrgb_pkg::CH_W];
  endfunction

  // expected 5-bit colour for one pixel
  function automatic rgb555_t hsb_to_rgb555(hsbrgb_pkg::chan_t hue, hsbrgb_pkg::chan_t sat,
                                            hsbrgb_pkg::chan_t val);
    logic [10:0]                   scaled;
    hsbrgb_pkg::sect_code_t        sector;
    hsbrgb_pkg::chan_t             off;
    logic [hsbrgb_pkg::PROD_W-1:0] sq;
    logic [hsbrgb_pkg::PROD_W-1:0] st;
    hsbrgb_pkg::chan_t             p;
    hsbrgb_pkg::chan_t             q;
    hsbrgb_pkg::chan_t             t;
    hsbrgb_pkg::chan_t             r;
    hsbrgb_pkg::chan_t             g;
    hsbrgb_pkg::chan_t             b;
    rgb555_t                       res;
    scaled = hue * 11'd6;
    sector = scaled[10:8];
    off    = scaled[7:0];
    sq     = sat * off;
    st     = sat * (8'd255 - off);
    p      = scale_level(val, sat);
    q      = scale_level(val, sq[hsbrgb_pkg::PROD_W-1:hsbrgb_pkg::CH_W]);
    t      = scale_level(val, st[hsbrgb_pkg::PROD_W-1:hsbrgb_pkg::CH_W]);
    if (sat == '0) begin
      // grey: every channel follows brightness
      r = val; g = val; b = val;
    end else begin
      case (sector)
        hsbrgb_pkg::SECT_RED_RISE_G:   begin r = val; g = t;   b = p;   end
        hsbrgb_pkg::SECT_GREEN_FALL_R: begin r = q;   g = val; b = p;   end
        hsbrgb_pkg::SECT_GREEN_RISE_B: begin r = p;   g = val; b = t;   end
        hsbrgb_pkg::SECT_BLUE_FALL_G:  begin r = p;   g = q;   b = val; end
        hsbrgb_pkg::SECT_BLUE_RISE_R:  begin r = t;   g = p;   b = val; end
        default:                       begin r = val; g = p;   b = q;   end
      endcase
    end
    res.red   = r[hsbrgb_pkg::CH_W-1:hsbrgb_pkg::CHAN_SHIFT];
    res.green = g[hsbrgb_pkg::CH_W-1:hsbrgb_pkg::CHAN_SHIFT];
    res.blue  = b[hsbrgb_pkg::CH_W-1:hsbrgb_pkg::CHAN_SHIFT];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic void queue_px(int h, int s, int v, bit drain = 1'b0);
    hsb_px_t px;
    px.hue = h[7:0];
    px.sat = s[7:0];
    px.val = v[7:0];
    px.drain_first = drain;
    pending_px.push_back(px);
  endfunction

  // sender: holds a transaction until it is taken, otherwise offers the next
  // pixel unless idling or waiting for the pipeline to drain
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        colour_due.push_back(hsb_to_rgb555(in_hue_in, in_sat_in, in_value_in));
        px_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_px.size() != 0 &&
            !(pending_px[0].drain_first && colour_due.size() != 0) &&
            ((px_sent >= CALM_LO && px_sent < CALM_HI) || $urandom_range(99) >= 6)) begin
          in_valid    <= 1'b1;
          in_hue_in   <= pending_px[0].hue;
          in_sat_in   <= pending_px[0].sat;
          in_value_in <= pending_px[0].val;
          pending_px.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each colour against the oldest prediction, stalls at
  // random, and once holds off long enough for the pipeline to fill and
  // push back on the sender
  always @(posedge clk) begin
    rgb555_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (colour_due.size() == 0) begin
          report_mismatch($sformatf("colour with nothing outstanding r=%0d g=%0d b=%0d",
                                    out_red_out, out_green_out, out_blue_out));
        end else begin
          want = colour_due.pop_front();
          if (out_red_out !== want.red)
            report_mismatch($sformatf("colour %0d red %0d, predicted %0d",
                                      colour_seen, out_red_out, want.red));
          if (out_green_out !== want.green)
            report_mismatch($sformatf("colour %0d green %0d, predicted %0d",
                                      colour_seen, out_green_out, want.green));
          if (out_blue_out !== want.blue)
            report_mismatch($sformatf("colour %0d blue %0d, predicted %0d",
                                      colour_seen, out_blue_out, want.blue));
        end
        colour_seen++;
        if (colour_seen == HOLD_AT)
          hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (colour_seen >= CALM_LO && colour_seen < CALM_HI) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 6);
      end
    end
  end

  // watchdog on progress rather than on total run time
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("stalled: no transaction for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int hue_edges[10] = '{42, 43, 85, 86, 128, 170, 171, 213, 214, 255};
    int pick;
    int s;
    int v;
    int h;

    // directed: extremes, grey, and every sector edge at full colour
    queue_px(0, 0, 0);
    queue_px(255, 255, 255);
    queue_px(0, 0, 255);
    queue_px(200, 0, 128);
    queue_px(0, 255, 255);
    queue_px(0, 1, 255);
    queue_px(100, 255, 0);
    queue_px(128, 255, 255);
    foreach (hue_edges[i])
      queue_px(hue_edges[i], 255, 255);
    queue_px(171, 128, 200);
    queue_px(60, 1, 1);
    queue_px(255, 200, 7);

    // random: mostly full range, weighted towards grey and field extremes
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      pick = $urandom_range(99);
      if (pick < 10)      s = 0;
      else if (pick < 18) s = ($urandom_range(1) != 0) ? 255 : 1;
      else                s = $urandom_range(255);
      pick = $urandom_range(99);
      if (pick < 8)       v = ($urandom_range(1) != 0) ? 255 : 0;
      else                v = $urandom_range(255);
      pick = $urandom_range(99);
      if (pick < 10)      h = hue_edges[$urandom_range(9)];
      else                h = $urandom_range(255);
      // pause the sender once until the pipeline has emptied
      queue_px(h, s, v, (i == 500));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_px.size() != 0 || in_valid)
      @(posedge clk);
    while (colour_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ filelist.f @@
src/hsbrgb_pkg.sv
src/hsbrgb_sector_stage.sv
src/hsbrgb_weight_stage.sv
src/hsbrgb_level_stage.sv
src/hsbrgb_mux_stage.sv
src/hsb_to_rgb555_converter_top.sv
verif/hsb_to_rgb555_converter_top_tb.sv
